[sv/kas_pkg.sv]
// kas_pkg: shared types and constants for the keyframe animation sampler
// used by kas_ctrl, kas_dp and keyframe_animation_sampler_top
package kas_pkg;

	localparam int NCH = 3;
	localparam logic [1:0] CH_POS = 2'd0;
	localparam logic [1:0] CH_SCL = 2'd1;
	localparam logic [1:0] CH_ROT = 2'd2;

	localparam logic KIND_LOAD   = 1'b0;
	localparam logic KIND_SAMPLE = 1'b1;

	// datapath operations issued by the controller
	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,     // write one key slot
		OP_SCAN_RD,  // issue read of frame at scan index
		OP_SCAN_CMP, // compare returned frame
		OP_RD_LO,    // read lo slot
		OP_RD_HI,    // read hi slot
		OP_DIV_INIT, // start t division
		OP_DIV_STEP, // one quotient bit
		OP_LERP,     // one component multiply-add, step index in cmd
		OP_SQ,       // one squared component into sum
		OP_SQRT_INIT,
		OP_SQRT_STEP,
		OP_NRM_INIT, // start normalize divide of one component
		OP_NRM_STEP,
		OP_NRM_DONE,
		OP_OUT       // load output register
	} dp_op_t;

	typedef struct packed {
		dp_op_t     op;
		logic [1:0] comp;  // component index
		logic       phase; // lerp partial product select
	} dp_cmd_t;

	typedef struct packed {
		logic found;    // scanned frame greater than sample frame
		logic zero_span;
		logic len_zero;
	} dp_sts_t;

endpackage

[sv/keyframe_animation_sampler_top.sv]
// keyframe_animation_sampler_top: apb registers, controller and datapath
// a load word is written to key memory in the cycle after it is accepted; a sample word runs
// each enabled channel in turn: key scan, lo and hi reads, t divide, lerp, output and valid;
// rotation also sums squares, takes the square root and renormalizes each component
// a zero span leaves the divide early and skips the lerp and renormalize; one word at a time
// arst_n clears key counts and control; key memories hold no reset value
module keyframe_animation_sampler_top #(
	parameter int MAX_KEYS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        kind,
	input  logic [1:0]  channel,
	input  logic [5:0]  key_index,
	input  logic [23:0] frame,
	input  logic signed [31:0] comp_x,
	input  logic signed [31:0] comp_y,
	input  logic signed [31:0] comp_z,
	input  logic signed [31:0] comp_w,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  out_channel,
	output logic signed [31:0] out_x,
	output logic signed [31:0] out_y,
	output logic signed [31:0] out_z,
	output logic signed [31:0] out_w,
	output logic        last,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import kas_pkg::*;

	localparam int IW = (MAX_KEYS > 64) ? $clog2(MAX_KEYS) : 6;
	localparam int AW = $clog2(NCH * MAX_KEYS);
	localparam int CW = 7;

	logic [CW-1:0] cnt_q [3];
	logic [23:0] sframe_q;
	logic busy;
	dp_cmd_t cmd;
	dp_sts_t sts;
	logic [1:0] ch;
	logic [IW-1:0] idx, lo_idx, hi_idx, dp_idx;
	logic [127:0] res;
	logic in_fire, load_ok;

	assign pready = 1'b1;
	assign in_ready = !busy;
	assign in_fire = in_valid && in_ready;
	// loads beyond the table or to channel three are dropped
	assign load_ok = (channel < 2'd3) && (32'(key_index) < MAX_KEYS);

	// key count registers, saturated at the table size
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++) cnt_q[k] <= '0;
		end else if (psel && penable && pwrite) begin
			if (paddr[3:2] < 2'd3) begin
				if (32'(pwdata[6:0]) > MAX_KEYS) cnt_q[paddr[3:2]] <= CW'(MAX_KEYS);
				else cnt_q[paddr[3:2]] <= pwdata[6:0];
			end
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[3:2] < 2'd3) prdata = 32'(cnt_q[paddr[3:2]]);
	end

	// sample frame held for the whole sample word
	always_ff @(posedge clk) begin
		if (in_fire) sframe_q <= frame;
	end

	// a load writes memory in the cycle after accept using registered key data
	logic [IW-1:0] lidx_q;
	logic [23:0] lframe_q;
	logic [127:0] lval_q;
	always_ff @(posedge clk) begin
		if (in_fire) begin
			lidx_q <= IW'(key_index);
			lframe_q <= frame;
			lval_q <= {comp_w, comp_z, comp_y, comp_x};
		end
	end

	assign dp_idx = (cmd.op == OP_LOAD) ? lidx_q : idx;

	kas_ctrl #(.IW(IW), .CW(CW)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .kind(kind),
		.in_ch(channel), .load_ok(load_ok), .cnt(cnt_q),
		.sts(sts), .out_ready(out_ready), .busy(busy), .cmd(cmd), .ch(ch),
		.idx(idx), .lo_idx(lo_idx), .hi_idx(hi_idx), .out_valid(out_valid),
		.out_last(last)
	);

	kas_dp #(.MAX_KEYS(MAX_KEYS), .IW(IW), .AW(AW)) u_dp (
		.clk(clk), .cmd(cmd), .ch(ch), .idx(dp_idx), .lo_idx(lo_idx),
		.hi_idx(hi_idx), .frame_in(lframe_q), .val_in(lval_q), .sframe(sframe_q),
		.sts(sts), .res(res)
	);

	assign out_channel = ch;
	assign out_x = res[31:0];
	assign out_y = res[63:32];
	assign out_z = res[95:64];
	assign out_w = res[127:96];

`ifndef NO_ASSERTIONS
	// no new word is taken while a result is pending
	a_no_accept_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("accept during output");
	// only rotation results carry w
	a_w_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_channel != CH_ROT) |-> (out_w == 32'd0))
		else $error("w set on non-rotation");
`endif

endmodule

[sv/kas_dp.sv]
// kas_dp: key memories, scan compare, divider, lerp, square root, normalizer
// depends on kas_pkg
module kas_dp #(
	parameter int MAX_KEYS = 64,
	parameter int IW = 6,
	parameter int AW = 8
) (
	input  logic               clk,
	input  kas_pkg::dp_cmd_t   cmd,
	input  logic [1:0]         ch,
	input  logic [IW-1:0]      idx,   // slot index for load or scan
	input  logic [IW-1:0]      lo_idx,
	input  logic [IW-1:0]      hi_idx,
	input  logic [23:0]        frame_in,
	input  logic [127:0]       val_in,
	input  logic [23:0]        sframe,
	output kas_pkg::dp_sts_t   sts,
	output logic [127:0]       res
);
	import kas_pkg::*;

	localparam int SLOTS = NCH * MAX_KEYS;

	logic [23:0]  fmem [SLOTS];
	logic [127:0] vmem [SLOTS];
	logic [23:0]  frd_q;
	logic [127:0] vrd_q;
	logic [23:0]  f0_q, f1_q;
	logic [127:0] v0_q, v1_q;
	logic [AW-1:0] addr;
	logic [AW-1:0] sel_idx;

	// divider state
	logic [40:0] rem_q;
	logic [23:0] den_q;
	logic [16:0] quo_q;
	// lerp
	logic signed [63:0] acc_q;
	logic signed [31:0] c_q [4];
	// norm
	logic [65:0] sum_q;
	logic [65:0] sv_q, sres_q, sbit_q;
	logic [31:0] len_q;
	logic [47:0] nrem_q, nquo_q;
	logic [47:0] ndiv_q; // shifting dividend bits

	always_comb begin
		logic [IW-1:0] ii;
		case (cmd.op)
			OP_RD_LO: ii = lo_idx;
			OP_RD_HI: ii = hi_idx;
			default:  ii = idx;
		endcase
		sel_idx = AW'(ii);
		addr = AW'(ch) * AW'(MAX_KEYS) + sel_idx;
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_LOAD) begin
			fmem[addr] <= frame_in;
			vmem[addr] <= val_in;
		end
		frd_q <= fmem[addr];
		vrd_q <= vmem[addr];
	end

	// square root result is stable once the controller checks it
	assign sts.found     = sframe < frd_q;
	assign sts.zero_span = !(f1_q > f0_q);
	assign sts.len_zero  = (sres_q == 66'd0);

	logic signed [31:0] a_c, b_c;
	logic signed [32:0] mf;
	logic [31:0] mag;
	logic [41:0] rtry;
	logic [66:0] strial;
	logic [48:0] ntry;
	always_comb begin
		a_c = $signed(v0_q[32*cmd.comp +: 32]);
		b_c = $signed(v1_q[32*cmd.comp +: 32]);
		mf  = cmd.phase ? $signed({16'd0, quo_q})
			: $signed(33'd65536 - {16'd0, quo_q});
		mag = c_q[cmd.comp][31] ? 32'(-c_q[cmd.comp]) : 32'(c_q[cmd.comp]);
		rtry = {rem_q, 1'b0} - {18'd0, den_q};
		strial = {1'b0, sres_q} + {1'b0, sbit_q};
		ntry = {nrem_q, ndiv_q[47]} - {17'd0, len_q};
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_RD_LO: ;
			OP_RD_HI: begin
				f0_q <= frd_q;
				v0_q <= vrd_q;
			end
			OP_DIV_INIT: begin
				f1_q  <= frd_q;
				v1_q  <= vrd_q;
				den_q <= frd_q - f0_q;
				rem_q <= 41'(sframe - f0_q);
				quo_q <= '0;
			end
			OP_DIV_STEP: begin
				// restoring division; remainder shifted left once per step over 16 steps
				if (!rtry[41]) begin
					rem_q <= rtry[40:0];
					quo_q <= {quo_q[15:0], 1'b1};
				end else begin
					rem_q <= {rem_q[39:0], 1'b0};
					quo_q <= {quo_q[15:0], 1'b0};
				end
			end
			OP_LERP: begin
				if (!cmd.phase) acc_q <= 64'(a_c) * 64'(mf) + 64'sd32768;
				else begin
					c_q[cmd.comp] <= 32'((acc_q + 64'(b_c) * 64'(mf)) >>> 16);
				end
			end
			OP_SQ: begin
				if (cmd.comp == 2'd0) sum_q <= 66'((64'(mag) * 64'(mag)) >> 2);
				else sum_q <= sum_q + 66'((64'(mag) * 64'(mag)) >> 2);
			end
			OP_SQRT_INIT: begin
				sv_q   <= sum_q;
				sres_q <= '0;
				sbit_q <= 66'd1 << 64;
			end
			OP_SQRT_STEP: begin
				if (sv_q >= strial[65:0]) begin
					sv_q   <= sv_q - strial[65:0];
					sres_q <= (sres_q >> 1) + sbit_q;
				end else begin
					sres_q <= sres_q >> 1;
				end
				sbit_q <= sbit_q >> 2;
			end
			OP_NRM_INIT: begin
				len_q  <= 32'(sres_q);
				ndiv_q <= {1'b0, mag, 15'd0} + 48'(sres_q[32:1]);
				nrem_q <= '0;
				nquo_q <= '0;
			end
			OP_NRM_STEP: begin
				if (!ntry[48]) begin
					nrem_q <= ntry[47:0];
					nquo_q <= {nquo_q[46:0], 1'b1};
				end else begin
					nrem_q <= {nrem_q[46:0], ndiv_q[47]};
					nquo_q <= {nquo_q[46:0], 1'b0};
				end
				ndiv_q <= {ndiv_q[46:0], 1'b0};
			end
			OP_NRM_DONE: begin
				c_q[cmd.comp] <= c_q[cmd.comp][31] ? -$signed(nquo_q[31:0])
					: $signed(nquo_q[31:0]);
			end
			OP_OUT: begin
				// w only leaves for rotation
				if (sts.zero_span) begin
					res <= (ch != CH_ROT) ? {32'd0, v0_q[95:0]} : v0_q;
				end else begin
					res <= (ch != CH_ROT) ? {32'd0, c_q[2], c_q[1], c_q[0]}
						: {c_q[3], c_q[2], c_q[1], c_q[0]};
				end
			end
			default: ;
		endcase
	end

endmodule

[sv/kas_ctrl.sv]
// kas_ctrl: sequencer for loads and per-channel sampling
// depends on kas_pkg
module kas_ctrl #(
	parameter int IW = 6,
	parameter int CW = 7
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_fire,
	input  logic             kind,
	input  logic [1:0]       in_ch,
	input  logic             load_ok,
	input  logic [CW-1:0]    cnt [3],
	input  kas_pkg::dp_sts_t sts,
	input  logic             out_ready,
	output logic             busy,
	output kas_pkg::dp_cmd_t cmd,
	output logic [1:0]       ch,
	output logic [IW-1:0]    idx,
	output logic [IW-1:0]    lo_idx,
	output logic [IW-1:0]    hi_idx,
	output logic             out_valid,
	output logic             out_last
);
	import kas_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_CH, S_SRD, S_SCMP, S_RLO, S_RHI, S_DINIT, S_DIV,
		S_LERP, S_SQ, S_SQI, S_SQRT, S_NINIT, S_NSTEP, S_OUT, S_WAIT
	} state_t;

	state_t state_q;
	logic [CW-1:0] scan_q;
	logic [5:0] step_q;
	logic [2:0] lstep_q;

	function automatic logic later_en(input logic [1:0] c, input logic [CW-1:0] n [3]);
		later_en = 1'b0;
		for (int k = 0; k < 3; k++)
			if (k > int'(c) && n[k] != '0) later_en = 1'b1;
	endfunction

	assign busy = (state_q != S_IDLE);
	assign idx  = IW'(scan_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cmd <= '0;
			ch <= '0;
			scan_q <= '0;
			step_q <= '0;
			lstep_q <= '0;
			lo_idx <= '0;
			hi_idx <= '0;
			out_valid <= 1'b0;
			out_last <= 1'b0;
		end else begin
			cmd <= '0;
			case (state_q)
				S_IDLE: if (in_fire) begin
					if (kind == KIND_LOAD) begin
						if (load_ok) begin
							cmd.op <= OP_LOAD;
							ch <= in_ch;
						end
					end else begin
						ch <= CH_POS;
						state_q <= S_CH;
					end
				end
				S_CH: begin
					if (cnt[ch] == '0) begin
						if (later_en(ch, cnt)) ch <= ch + 2'd1;
						else state_q <= S_IDLE;
					end else begin
						scan_q <= '0;
						lo_idx <= '0;
						hi_idx <= '0;
						cmd.op <= OP_SCAN_RD;
						state_q <= S_SRD;
					end
				end
				S_SRD: state_q <= S_SCMP;
				S_SCMP: begin
					if (sts.found) begin
						hi_idx <= IW'(scan_q);
						state_q <= S_RLO;
					end else begin
						lo_idx <= IW'(scan_q);
						hi_idx <= IW'(scan_q);
						if (scan_q + 1'b1 >= cnt[ch]) state_q <= S_RLO;
						else begin
							scan_q <= scan_q + 1'b1;
							cmd.op <= OP_SCAN_RD;
							state_q <= S_SRD;
						end
					end
				end
				S_RLO: begin cmd.op <= OP_RD_LO; state_q <= S_RHI; end
				S_RHI: begin cmd.op <= OP_RD_HI; state_q <= S_DINIT; end
				S_DINIT: begin cmd.op <= OP_DIV_INIT; step_q <= '0; state_q <= S_DIV; end
				S_DIV: begin
					// the upper key frame lands with the divide init, so zero span is checked once step_q is nonzero
					if (step_q != 6'd0 && sts.zero_span) state_q <= S_OUT;
					else begin
						cmd.op <= OP_DIV_STEP;
						step_q <= step_q + 6'd1;
						if (step_q == 6'd16) begin
							cmd.op <= OP_NONE;
							lstep_q <= '0;
							state_q <= S_LERP;
						end
					end
				end
				S_LERP: begin
					cmd.op <= OP_LERP;
					cmd.comp <= lstep_q[2:1];
					cmd.phase <= lstep_q[0];
					lstep_q <= lstep_q + 3'd1;
					if (lstep_q == 3'd7) begin
						lstep_q <= '0;
						state_q <= (ch == CH_ROT) ? S_SQ : S_OUT;
					end
				end
				S_SQ: begin
					cmd.op <= OP_SQ;
					cmd.comp <= lstep_q[1:0];
					lstep_q <= lstep_q + 3'd1;
					if (lstep_q == 3'd3) state_q <= S_SQI;
				end
				S_SQI: begin cmd.op <= OP_SQRT_INIT; step_q <= '0; state_q <= S_SQRT; end
				S_SQRT: begin
					if (step_q == 6'd33) begin
						lstep_q <= '0;
						state_q <= S_NINIT;
					end else begin
						cmd.op <= OP_SQRT_STEP;
						step_q <= step_q + 6'd1;
					end
				end
				S_NINIT: begin
					if (sts.len_zero || lstep_q == 3'd4) state_q <= S_OUT;
					else begin
						cmd.op <= OP_NRM_INIT;
						cmd.comp <= lstep_q[1:0];
						step_q <= '0;
						state_q <= S_NSTEP;
					end
				end
				S_NSTEP: begin
					cmd.comp <= lstep_q[1:0];
					if (step_q == 6'd48) begin
						cmd.op <= OP_NRM_DONE;
						lstep_q <= lstep_q + 3'd1;
						state_q <= S_NINIT;
					end else begin
						cmd.op <= OP_NRM_STEP;
						step_q <= step_q + 6'd1;
					end
				end
				S_OUT: begin
					cmd.op <= OP_OUT;
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					// valid rises together with the loaded result word
					if (!out_valid) begin
						out_valid <= 1'b1;
						out_last <= !later_en(ch, cnt);
					end else if (out_ready) begin
						out_valid <= 1'b0;
						if (out_last) state_q <= S_IDLE;
						else begin
							ch <= ch + 2'd1;
							state_q <= S_CH;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
